@@ rtl/core/gdpe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdpe_pkg: shared types and constants of the pulse evaluator
// Field widths, register codes, fixed-point constants and the series tables.
// ----------------------------------------------------------------------------
package gdpe_pkg;

  localparam int TIME_BITS  = 32;
  localparam int TIME_RED   = (TIME_BITS < 32) ? TIME_BITS : 32;
  localparam int TIME_W     = 32;
  localparam int SPREAD_W   = 24;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int PULSE_W    = 32;

  localparam int AU_W    = 27;
  localparam int X20_W   = 23;
  localparam int XREM_W  = 47;
  localparam int E_W     = 34;
  localparam int CABS_W  = 31;
  localparam int P_W     = 34;
  localparam int NUM_W   = 61;
  localparam int S2_W    = 48;
  localparam int MAG_W   = 31;
  localparam int DSH_W   = 79;
  localparam int SUM_W   = 35;

  localparam int EXP_TERMS = 12;
  localparam int COS_TERMS = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPREAD = 2'd0,
    REG_DELAY  = 2'd1,
    REG_FREQ   = 2'd2
  } cfg_reg_t;

  localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
  localparam logic [31:0] LN2_Q32    = 32'd2977044472;
  localparam logic [30:0] PIHALF_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;

  localparam logic [8:0] EXP_DIV [1:12] = '{
    9'd1, 9'd2, 9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd12
  };
  localparam logic [8:0] COS_DIV [1:9] = '{
    9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240, 9'd306
  };
  localparam logic [8:0] SIN_DIV [1:9] = '{
    9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272, 9'd342
  };

  localparam logic [32:0] EXP_RECIP [1:12] = '{
    33'((64'd1 << 32) / 64'd1),  33'((64'd1 << 32) / 64'd2),
    33'((64'd1 << 32) / 64'd3),  33'((64'd1 << 32) / 64'd4),
    33'((64'd1 << 32) / 64'd5),  33'((64'd1 << 32) / 64'd6),
    33'((64'd1 << 32) / 64'd7),  33'((64'd1 << 32) / 64'd8),
    33'((64'd1 << 32) / 64'd9),  33'((64'd1 << 32) / 64'd10),
    33'((64'd1 << 32) / 64'd11), 33'((64'd1 << 32) / 64'd12)
  };
  localparam logic [32:0] COS_RECIP [1:9] = '{
    33'((64'd1 << 32) / 64'd2),   33'((64'd1 << 32) / 64'd12),
    33'((64'd1 << 32) / 64'd30),  33'((64'd1 << 32) / 64'd56),
    33'((64'd1 << 32) / 64'd90),  33'((64'd1 << 32) / 64'd132),
    33'((64'd1 << 32) / 64'd182), 33'((64'd1 << 32) / 64'd240),
    33'((64'd1 << 32) / 64'd306)
  };
  localparam logic [32:0] SIN_RECIP [1:9] = '{
    33'((64'd1 << 32) / 64'd6),   33'((64'd1 << 32) / 64'd20),
    33'((64'd1 << 32) / 64'd42),  33'((64'd1 << 32) / 64'd72),
    33'((64'd1 << 32) / 64'd110), 33'((64'd1 << 32) / 64'd156),
    33'((64'd1 << 32) / 64'd210), 33'((64'd1 << 32) / 64'd272),
    33'((64'd1 << 32) / 64'd342)
  };

  typedef struct packed {
    logic            valid;
    logic            zero;
    logic            uneg;
    logic            unz;
    logic [AU_W-1:0] au;
  } meta_t;

endpackage

@@ rtl/core/gdpe_series.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdpe_series: pipelined exponential and cosine series
// Turns the scaled offset into the Gaussian factor and the phase into the
// clamped carrier magnitude and sign, one Taylor term per three stages.
// ----------------------------------------------------------------------------
module gdpe_series (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gdpe_pkg::meta_t                     x_meta,
  input  logic [gdpe_pkg::X20_W-1:0]          x20,
  input  logic [31:0]                         phase,
  output gdpe_pkg::meta_t                     res_meta,
  output logic [gdpe_pkg::E_W-1:0]            e_val,
  output logic [gdpe_pkg::CABS_W-1:0]         c_abs,
  output logic                                c_neg,
  output logic                                c_nz
);

  typedef struct packed {
    gdpe_pkg::meta_t m;
    logic [5:0]      n;
    logic [29:0]     y;
    logic [31:0]     z2;
    logic [1:0]      q;
  } side_t;

  localparam int NSUB = 3 * gdpe_pkg::EXP_TERMS;

  gdpe_pkg::meta_t m1_r, m2_r;
  logic [36:0] a1_r;
  logic [30:0] z1_r, z1b_r;
  logic [1:0]  q1_r, q2_r;
  logic [37:0] b2_r;
  logic [31:0] z2_r;

  logic [45:0] xsq;
  logic [60:0] zp;
  logic [61:0] bp;
  logic [61:0] zz;
  logic [63:0] yp;

  side_t sd_r [0:NSUB];

  logic [31:0] te_r  [0:gdpe_pkg::EXP_TERMS];
  logic [31:0] xae_r [1:gdpe_pkg::EXP_TERMS];
  logic [31:0] xbe_r [1:gdpe_pkg::EXP_TERMS];
  logic [31:0] ebe_r [1:gdpe_pkg::EXP_TERMS];
  logic signed [gdpe_pkg::SUM_W-1:0] se_r  [0:gdpe_pkg::EXP_TERMS];
  logic signed [gdpe_pkg::SUM_W-1:0] sea_r [1:gdpe_pkg::EXP_TERMS];
  logic signed [gdpe_pkg::SUM_W-1:0] seb_r [1:gdpe_pkg::EXP_TERMS];

  logic [31:0] tc_r  [0:gdpe_pkg::COS_TERMS];
  logic [31:0] ts_r  [0:gdpe_pkg::COS_TERMS];
  logic [31:0] xac_r [1:gdpe_pkg::COS_TERMS];
  logic [31:0] xas_r [1:gdpe_pkg::COS_TERMS];
  logic [31:0] xbc_r [1:gdpe_pkg::COS_TERMS];
  logic [31:0] xbs_r [1:gdpe_pkg::COS_TERMS];
  logic [31:0] ebc_r [1:gdpe_pkg::COS_TERMS];
  logic [31:0] ebs_r [1:gdpe_pkg::COS_TERMS];
  logic signed [gdpe_pkg::SUM_W-1:0] sc_r  [0:gdpe_pkg::EXP_TERMS];
  logic signed [gdpe_pkg::SUM_W-1:0] ss_r  [0:gdpe_pkg::EXP_TERMS];
  logic signed [gdpe_pkg::SUM_W-1:0] sca_r [1:gdpe_pkg::EXP_TERMS];
  logic signed [gdpe_pkg::SUM_W-1:0] ssa_r [1:gdpe_pkg::EXP_TERMS];
  logic signed [gdpe_pkg::SUM_W-1:0] scb_r [1:gdpe_pkg::EXP_TERMS];
  logic signed [gdpe_pkg::SUM_W-1:0] ssb_r [1:gdpe_pkg::EXP_TERMS];

  side_t f1_sd_r;
  logic signed [gdpe_pkg::SUM_W-1:0] f1_se_r, f1_sc_r, f1_ss_r;

  logic signed [gdpe_pkg::SUM_W-1:0] base;
  logic [gdpe_pkg::SUM_W-1:0]        babs;
  logic [gdpe_pkg::E_W-1:0]          e_nxt;
  logic [gdpe_pkg::CABS_W-1:0]       cabs_nxt;
  logic                              cneg_nxt;
  logic                              cnz_nxt;

  gdpe_pkg::meta_t                   res_meta_r;
  logic [gdpe_pkg::E_W-1:0]          e_r;
  logic [gdpe_pkg::CABS_W-1:0]       cabs_r;
  logic                              cneg_r;
  logic                              cnz_r;

  always_comb begin
    xsq = 46'(x20) * 46'(x20);
    zp  = 61'(phase[29:0]) * 61'(gdpe_pkg::PIHALF_Q30);
    bp  = 62'(a1_r[36:6]) * 62'(gdpe_pkg::LOG2E_Q30);
    zz  = 62'(z1_r) * 62'(z1_r);
    yp  = 64'(b2_r[31:0]) * 64'(gdpe_pkg::LN2_Q32);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_r <= '0;
      m2_r <= '0;
    end else begin
      m1_r  <= x_meta;
      a1_r  <= xsq[45:9];
      z1_r  <= zp[60:30];
      q1_r  <= phase[31:30];
      m2_r  <= m1_r;
      b2_r  <= bp[61:24];
      z2_r  <= zz[61:30];
      z1b_r <= z1_r;
      q2_r  <= q1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_r[0] <= '0;
    end else begin
      sd_r[0].m  <= m2_r;
      sd_r[0].n  <= b2_r[37:32];
      sd_r[0].y  <= yp[63:34];
      sd_r[0].z2 <= z2_r;
      sd_r[0].q  <= q2_r;
      te_r[0]    <= 32'(gdpe_pkg::ONE_Q30);
      se_r[0]    <= '0;
      tc_r[0]    <= 32'(gdpe_pkg::ONE_Q30);
      ts_r[0]    <= 32'(z1b_r);
      sc_r[0]    <= '0;
      ss_r[0]    <= '0;
    end
  end

  for (genvar g = 1; g <= gdpe_pkg::EXP_TERMS; g++) begin : g_term
    localparam bit SUB = ((g - 1) % 2) == 1;

    logic [63:0] pe;
    logic [64:0] qe;
    logic [31:0] re;
    logic signed [gdpe_pkg::SUM_W-1:0] se_nxt;

    always_comb begin
      pe = 64'(te_r[g-1]) * 64'(sd_r[3*g-3].y);
      qe = 65'(xae_r[g]) * 65'(gdpe_pkg::EXP_RECIP[g]);
      re = xbe_r[g] - 32'(ebe_r[g] * 32'(gdpe_pkg::EXP_DIV[g]));
      if (SUB) begin
        se_nxt = se_r[g-1] - $signed(gdpe_pkg::SUM_W'(te_r[g-1]));
      end else begin
        se_nxt = se_r[g-1] + $signed(gdpe_pkg::SUM_W'(te_r[g-1]));
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sd_r[3*g-2] <= '0;
        sd_r[3*g-1] <= '0;
        sd_r[3*g]   <= '0;
      end else begin
        sd_r[3*g-2] <= sd_r[3*g-3];
        sd_r[3*g-1] <= sd_r[3*g-2];
        sd_r[3*g]   <= sd_r[3*g-1];
        xae_r[g]    <= pe[61:30];
        sea_r[g]    <= se_nxt;
        xbe_r[g]    <= xae_r[g];
        ebe_r[g]    <= qe[63:32];
        seb_r[g]    <= sea_r[g];
        te_r[g]     <= ebe_r[g] + 32'(re >= 32'(gdpe_pkg::EXP_DIV[g]));
        se_r[g]     <= seb_r[g];
        scb_r[g]    <= sca_r[g];
        ssb_r[g]    <= ssa_r[g];
        sc_r[g]     <= scb_r[g];
        ss_r[g]     <= ssb_r[g];
      end
    end

    if (g <= gdpe_pkg::COS_TERMS + 1) begin : g_csum
      logic signed [gdpe_pkg::SUM_W-1:0] sc_nxt, ss_nxt;

      always_comb begin
        if (SUB) begin
          sc_nxt = sc_r[g-1] - $signed(gdpe_pkg::SUM_W'(tc_r[g-1]));
          ss_nxt = ss_r[g-1] - $signed(gdpe_pkg::SUM_W'(ts_r[g-1]));
        end else begin
          sc_nxt = sc_r[g-1] + $signed(gdpe_pkg::SUM_W'(tc_r[g-1]));
          ss_nxt = ss_r[g-1] + $signed(gdpe_pkg::SUM_W'(ts_r[g-1]));
        end
      end

      always_ff @(posedge clk) begin
        sca_r[g] <= sc_nxt;
        ssa_r[g] <= ss_nxt;
      end
    end else begin : g_chold
      always_ff @(posedge clk) begin
        sca_r[g] <= sc_r[g-1];
        ssa_r[g] <= ss_r[g-1];
      end
    end

    if (g <= gdpe_pkg::COS_TERMS) begin : g_cos
      logic [63:0] pc, ps;
      logic [64:0] qc, qs;
      logic [31:0] rc, rs;

      always_comb begin
        pc = 64'(tc_r[g-1]) * 64'(sd_r[3*g-3].z2);
        ps = 64'(ts_r[g-1]) * 64'(sd_r[3*g-3].z2);
        qc = 65'(xac_r[g]) * 65'(gdpe_pkg::COS_RECIP[g]);
        qs = 65'(xas_r[g]) * 65'(gdpe_pkg::SIN_RECIP[g]);
        rc = xbc_r[g] - 32'(ebc_r[g] * 32'(gdpe_pkg::COS_DIV[g]));
        rs = xbs_r[g] - 32'(ebs_r[g] * 32'(gdpe_pkg::SIN_DIV[g]));
      end

      always_ff @(posedge clk) begin
        xac_r[g] <= pc[61:30];
        xas_r[g] <= ps[61:30];
        xbc_r[g] <= xac_r[g];
        xbs_r[g] <= xas_r[g];
        ebc_r[g] <= qc[63:32];
        ebs_r[g] <= qs[63:32];
        tc_r[g]  <= ebc_r[g] + 32'(rc >= 32'(gdpe_pkg::COS_DIV[g]));
        ts_r[g]  <= ebs_r[g] + 32'(rs >= 32'(gdpe_pkg::SIN_DIV[g]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_sd_r <= '0;
    end else begin
      f1_sd_r <= sd_r[NSUB];
      f1_se_r <= se_r[gdpe_pkg::EXP_TERMS]
               + $signed(gdpe_pkg::SUM_W'(te_r[gdpe_pkg::EXP_TERMS]));
      f1_sc_r <= sc_r[gdpe_pkg::EXP_TERMS];
      f1_ss_r <= ss_r[gdpe_pkg::EXP_TERMS];
    end
  end

  always_comb begin
    if (f1_se_r[gdpe_pkg::SUM_W-1] || (f1_sd_r.n == 6'd63)) begin
      e_nxt = '0;
    end else begin
      e_nxt = f1_se_r[gdpe_pkg::E_W-1:0] >> f1_sd_r.n;
    end
    base = f1_sd_r.q[0] ? f1_ss_r : f1_sc_r;
    babs = base[gdpe_pkg::SUM_W-1] ? gdpe_pkg::SUM_W'(-base) : gdpe_pkg::SUM_W'(base);
    if (babs > gdpe_pkg::SUM_W'(gdpe_pkg::ONE_Q30)) begin
      cabs_nxt = gdpe_pkg::ONE_Q30;
    end else begin
      cabs_nxt = babs[gdpe_pkg::CABS_W-1:0];
    end
    cneg_nxt = f1_sd_r.q[1] ^ f1_sd_r.q[0] ^ base[gdpe_pkg::SUM_W-1];
    cnz_nxt  = babs != '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_meta_r <= '0;
    end else begin
      res_meta_r <= f1_sd_r.m;
      e_r        <= e_nxt;
      cabs_r     <= cabs_nxt;
      cneg_r     <= cneg_nxt;
      cnz_r      <= cnz_nxt;
    end
  end

  assign res_meta = res_meta_r;
  assign e_val    = e_r;
  assign c_abs    = cabs_r;
  assign c_neg    = cneg_r;
  assign c_nz     = cnz_r;

endmodule

@@ rtl/core/gaussian_derivative_pulse_eval_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_derivative_pulse_eval_core: modulated Gaussian-derivative pulse
// Evaluates one sample of the cosine-modulated Gaussian-derivative pulse per
// request, as a saturated signed Q1.30 value.
//
//   Channel   Ports                                   Handshake
//   input     in_time_ticks                           start & !busy
//   result    out_pulse_value                         out_strobe, one cycle
//   config    cfg_index, cfg_data                     cfg_we
//
// A request may be accepted in every cycle; busy stays low.
// Each request flows through the two bit-per-stage dividers and the
// three-stage-per-term series pipeline that lies between them.
// Reset clears the valid bits and loads the register defaults.
// Results cannot be held off, so nothing in the pipeline ever stalls.
// ----------------------------------------------------------------------------
module gaussian_derivative_pulse_eval_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [gdpe_pkg::TIME_W-1:0]     in_time_ticks,
  input  logic                                   cfg_we,
  input  logic [gdpe_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [gdpe_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic                                   out_strobe,
  output logic signed [gdpe_pkg::PULSE_W-1:0]    out_pulse_value
);

  typedef struct packed {
    gdpe_pkg::meta_t m;
    logic            neg;
    logic            sat;
  } tail_t;

  logic [gdpe_pkg::SPREAD_W-1:0] spread_r;
  logic signed [31:0]            delay_r;
  logic [31:0]                   freq_r;
  logic [gdpe_pkg::S2_W-1:0]     s2_r;

  logic        acc;
  logic signed [32:0] t_ext, d_ext;
  logic [31:0] ph_nxt;

  logic        v1_r, v2_r;
  logic signed [32:0] u1_r;
  logic [31:0] ph1_r, ph2_r;
  logic [32:0] au2_r;
  logic        uneg2_r, unz2_r;

  gdpe_pkg::meta_t xm_r [0:gdpe_pkg::X20_W];
  logic [gdpe_pkg::XREM_W-1:0] xrem_r [0:gdpe_pkg::X20_W];
  logic [gdpe_pkg::X20_W-1:0]  xquo_r [0:gdpe_pkg::X20_W];
  logic [31:0]                 xph_r  [0:gdpe_pkg::X20_W];

  gdpe_pkg::meta_t              sr_meta;
  logic [gdpe_pkg::E_W-1:0]     sr_e;
  logic [gdpe_pkg::CABS_W-1:0]  sr_cabs;
  logic                         sr_cneg, sr_cnz;

  logic [64:0]                  pp;
  gdpe_pkg::meta_t              m3_r, m4_r;
  logic [gdpe_pkg::P_W-1:0]     p3_r;
  logic                         neg3_r, neg4_r;
  logic [gdpe_pkg::NUM_W-1:0]   n4_r;

  tail_t                        tl_r   [0:gdpe_pkg::MAG_W];
  logic [gdpe_pkg::NUM_W-1:0]   mrem_r [0:gdpe_pkg::MAG_W];
  logic [gdpe_pkg::MAG_W-1:0]   mquo_r [0:gdpe_pkg::MAG_W];

  logic                         out_strobe_r;
  logic [gdpe_pkg::PULSE_W-1:0] out_value_r;
  logic [gdpe_pkg::PULSE_W-1:0] out_value_nxt;

  assign busy = 1'b0;
  assign acc  = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spread_r <= gdpe_pkg::SPREAD_W'(1);
      delay_r  <= '0;
      freq_r   <= '0;
      s2_r     <= gdpe_pkg::S2_W'(1);
    end else begin
      s2_r <= gdpe_pkg::S2_W'(spread_r) * gdpe_pkg::S2_W'(spread_r);
      if (cfg_we) begin
        unique case (cfg_index)
          gdpe_pkg::REG_SPREAD: begin
            spread_r <= (cfg_data[gdpe_pkg::SPREAD_W-1:0] == '0)
                      ? gdpe_pkg::SPREAD_W'(1) : cfg_data[gdpe_pkg::SPREAD_W-1:0];
          end
          gdpe_pkg::REG_DELAY: begin
            delay_r <= $signed(cfg_data);
          end
          gdpe_pkg::REG_FREQ: begin
            freq_r <= cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    t_ext  = $signed({{(33 - gdpe_pkg::TIME_RED){in_time_ticks[gdpe_pkg::TIME_RED-1]}},
                      in_time_ticks[gdpe_pkg::TIME_RED-1:0]});
    d_ext  = $signed({{(33 - gdpe_pkg::TIME_RED){delay_r[gdpe_pkg::TIME_RED-1]}},
                      delay_r[gdpe_pkg::TIME_RED-1:0]});
    ph_nxt = freq_r * $unsigned(in_time_ticks);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r    <= acc;
      u1_r    <= t_ext - d_ext;
      ph1_r   <= ph_nxt;
      v2_r    <= v1_r;
      au2_r   <= u1_r[32] ? 33'(-u1_r) : 33'(u1_r);
      uneg2_r <= u1_r[32];
      unz2_r  <= u1_r != '0;
      ph2_r   <= ph1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xm_r[0] <= '0;
    end else begin
      xm_r[0].valid <= v2_r;
      xm_r[0].zero  <= au2_r >= {6'b0, spread_r, 3'b000};
      xm_r[0].uneg  <= uneg2_r;
      xm_r[0].unz   <= unz2_r;
      xm_r[0].au    <= au2_r[gdpe_pkg::AU_W-1:0];
      xrem_r[0]     <= {au2_r[gdpe_pkg::AU_W-1:0], 20'b0};
      xquo_r[0]     <= '0;
      xph_r[0]      <= ph2_r;
    end
  end

  for (genvar j = 0; j < gdpe_pkg::X20_W; j++) begin : g_xdiv
    localparam int SH = gdpe_pkg::X20_W - 1 - j;

    logic [gdpe_pkg::XREM_W-1:0] dsh;
    logic                        ge;

    always_comb begin
      dsh = gdpe_pkg::XREM_W'(spread_r) << SH;
      ge  = xrem_r[j] >= dsh;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        xm_r[j+1] <= '0;
      end else begin
        xm_r[j+1]   <= xm_r[j];
        xrem_r[j+1] <= ge ? (xrem_r[j] - dsh) : xrem_r[j];
        xquo_r[j+1] <= {xquo_r[j][gdpe_pkg::X20_W-2:0], ge};
        xph_r[j+1]  <= xph_r[j];
      end
    end
  end

  gdpe_series u_series (
    .clk      (clk),
    .rst_n    (rst_n),
    .x_meta   (xm_r[gdpe_pkg::X20_W]),
    .x20      (xquo_r[gdpe_pkg::X20_W]),
    .phase    (xph_r[gdpe_pkg::X20_W]),
    .res_meta (sr_meta),
    .e_val    (sr_e),
    .c_abs    (sr_cabs),
    .c_neg    (sr_cneg),
    .c_nz     (sr_cnz)
  );

  assign pp = 65'(sr_e) * 65'(sr_cabs);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_r <= '0;
      m4_r <= '0;
    end else begin
      m3_r   <= sr_meta;
      p3_r   <= pp[63:30];
      neg3_r <= sr_meta.unz & sr_cnz & (sr_meta.uneg == sr_cneg);
      m4_r   <= m3_r;
      n4_r   <= gdpe_pkg::NUM_W'(m3_r.au) * gdpe_pkg::NUM_W'(p3_r);
      neg4_r <= neg3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tl_r[0] <= '0;
    end else begin
      tl_r[0].m   <= m4_r;
      tl_r[0].neg <= neg4_r;
      tl_r[0].sat <= gdpe_pkg::DSH_W'(n4_r) >= {s2_r, 31'b0};
      mrem_r[0]   <= n4_r;
      mquo_r[0]   <= '0;
    end
  end

  for (genvar j = 0; j < gdpe_pkg::MAG_W; j++) begin : g_mdiv
    localparam int SH = gdpe_pkg::MAG_W - 1 - j;

    logic [gdpe_pkg::DSH_W-1:0] dsh;
    logic [gdpe_pkg::DSH_W-1:0] diff;
    logic                       ge;

    always_comb begin
      dsh  = gdpe_pkg::DSH_W'(s2_r) << SH;
      ge   = gdpe_pkg::DSH_W'(mrem_r[j]) >= dsh;
      diff = gdpe_pkg::DSH_W'(mrem_r[j]) - dsh;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tl_r[j+1] <= '0;
      end else begin
        tl_r[j+1]   <= tl_r[j];
        mrem_r[j+1] <= ge ? diff[gdpe_pkg::NUM_W-1:0] : mrem_r[j];
        mquo_r[j+1] <= {mquo_r[j][gdpe_pkg::MAG_W-2:0], ge};
      end
    end
  end

  always_comb begin
    priority if (tl_r[gdpe_pkg::MAG_W].m.zero) begin
      out_value_nxt = '0;
    end else if (tl_r[gdpe_pkg::MAG_W].sat) begin
      out_value_nxt = tl_r[gdpe_pkg::MAG_W].neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (tl_r[gdpe_pkg::MAG_W].neg) begin
      out_value_nxt = 32'(-{1'b0, mquo_r[gdpe_pkg::MAG_W]});
    end else begin
      out_value_nxt = {1'b0, mquo_r[gdpe_pkg::MAG_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= tl_r[gdpe_pkg::MAG_W].m.valid;
      out_value_r  <= out_value_nxt;
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_pulse_value = $signed(out_value_r);

endmodule
